>>> rtl/core/pfa_pkg.sv
package pfa_pkg;

    // Fixed field widths
    localparam int PAGE_W   = 8;
    localparam int FRAME_W  = 7;
    localparam int STATUS_W = 3;
    localparam int PAGES    = 2 ** PAGE_W;

    // Request modes
    localparam logic MODE_ALLOCATE = 1'b0;
    localparam logic MODE_FREE     = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_ALLOCATED      = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FREED          = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_ALREADY_MAPPED = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE_FRAME  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NOT_MAPPED     = 3'd4;

    // Request transaction
    typedef struct packed {
        logic              mode;
        logic [PAGE_W-1:0] virtual_page;
        logic              write_access;
    } req_t;

    // Response transaction
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  frame;
        logic                writable;
    } rsp_t;

    // Page table entry as kept in the table memory
    typedef struct packed {
        logic               valid;
        logic               writable;
        logic [FRAME_W-1:0] frame;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> rtl/core/pfa_stream_if.sv
interface pfa_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/pfa_ram.sv
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/pfa_frame_map.sv
module pfa_frame_map #(
    parameter int FRAMES = 128,
    localparam int FIDX_W = $clog2(FRAMES)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              set_en,
    input  logic [FIDX_W-1:0] set_idx,
    input  logic              clr_en,
    input  logic [FIDX_W-1:0] clr_idx,
    output logic              free_found,
    output logic [FIDX_W-1:0] free_idx
);

    logic [FRAMES-1:0] used_reg;
    logic [FRAMES-1:0] used_next;

    // Mark a frame taken or release one
    always_comb
    begin
        used_next = used_reg;
        if (clr_en)
        begin
            used_next[clr_idx] = 1'b0;
        end
        if (set_en)
        begin
            used_next[set_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    // Pick the lowest free frame
    always_comb
    begin
        free_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = FIDX_W'(i);
            end
        end
    end

    assign free_found = ~&used_reg;

endmodule

>>> rtl/core/page_frame_allocator.sv
// Page frame allocator. Each request transaction either maps a virtual page
// to the lowest-numbered free physical frame (mode 0) or unmaps it (mode 1),
// and yields exactly one response transaction with a status, the frame and,
// on a new mapping, the writable bit it stores. The page table sits in a
// synchronous RAM with a registered read port; the frame in-use bitmap sits
// in flip-flops with a priority encoder. A request has two steps, the table
// read and then the decision with the write-back; the next request is taken
// only after that decision, which waits while a held response is not taken.
// The response register lets the next request enter while an earlier
// response still waits. After reset the block clears all page table entries,
// min(ENTRIES_PER_DIRECTORY * DIRECTORIES, 256), and takes no request meanwhile.
module page_frame_allocator
    import pfa_pkg::*;
#(
    parameter int ENTRIES_PER_DIRECTORY = 16,
    parameter int DIRECTORIES           = 16,
    parameter int FRAMES                = 128
) (
    input  logic         clk,
    input  logic         rst_n,
    pfa_stream_if.sink   req,
    pfa_stream_if.source rsp
);

    // Only table indexes up to the page number itself are reachable
    localparam int TABLE_FULL  = ENTRIES_PER_DIRECTORY * DIRECTORIES;
    localparam int TABLE_DEPTH = (TABLE_FULL < PAGES) ? TABLE_FULL : PAGES;
    localparam int TIW         = $clog2(TABLE_DEPTH);
    localparam int FIDX_W      = $clog2(FRAMES);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [TIW-1:0]   clr_cnt_reg;
    logic [TIW-1:0]   clr_cnt_next;
    logic             mode_reg;
    logic             wr_reg;
    logic [TIW-1:0]   idx_reg;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_t             rsp_data_reg;
    rsp_t             rsp_data_next;

    logic [TIW-1:0]   idx_lut [PAGES];
    logic             req_fire;
    logic             exec_fire;
    logic             clearing;
    entry_t           rd_entry;
    logic [ENTRY_W-1:0] rd_word;
    logic             alloc_ok;
    logic             free_ok;
    logic             ram_we;
    logic [TIW-1:0]   ram_waddr;
    entry_t           ram_wdata;
    logic             free_found;
    logic [FIDX_W-1:0] free_idx;
    logic             map_clr_en;

    // Page number to table index, directory wrapped
    for (genvar p = 0; p < PAGES; p++)
    begin : g_idx_lut
        assign idx_lut[p] = TIW'(((p / ENTRIES_PER_DIRECTORY) % DIRECTORIES)
                                 * ENTRIES_PER_DIRECTORY
                                 + (p % ENTRIES_PER_DIRECTORY));
    end

    assign clearing  = (state_reg == ST_CLEAR);
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign exec_fire = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp.ready);

    // Decide the outcome from the entry just read
    assign rd_entry = entry_t'(rd_word);
    assign alloc_ok = !mode_reg && !rd_entry.valid && free_found;
    assign free_ok  = mode_reg && rd_entry.valid;

    // Table write: clearing pass or write-back
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = '0;
        if (clearing)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
        end
        else if (exec_fire && (alloc_ok || free_ok))
        begin
            ram_we = 1'b1;
            if (alloc_ok)
            begin
                ram_wdata.valid    = 1'b1;
                ram_wdata.writable = wr_reg;
                ram_wdata.frame    = FRAME_W'(free_idx);
            end
        end
    end

    pfa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (req_fire),
        .raddr (idx_lut[req.data.virtual_page]),
        .rdata (rd_word)
    );

    assign map_clr_en = exec_fire && free_ok && (int'(rd_entry.frame) < FRAMES);

    pfa_frame_map #(
        .FRAMES (FRAMES)
    ) u_frame_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .set_en     (exec_fire && alloc_ok),
        .set_idx    (free_idx),
        .clr_en     (map_clr_en),
        .clr_idx    (FIDX_W'(rd_entry.frame)),
        .free_found (free_found),
        .free_idx   (free_idx)
    );

    // Sequence clear, accept and execute
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == TIW'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Build the response
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (exec_fire)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = '0;
            if (!mode_reg)
            begin
                if (rd_entry.valid)
                begin
                    rsp_data_next.status = STATUS_ALREADY_MAPPED;
                end
                else if (!free_found)
                begin
                    rsp_data_next.status = STATUS_NO_FREE_FRAME;
                end
                else
                begin
                    rsp_data_next.status   = STATUS_ALLOCATED;
                    rsp_data_next.frame    = FRAME_W'(free_idx);
                    rsp_data_next.writable = wr_reg;
                end
            end
            else
            begin
                if (rd_entry.valid)
                begin
                    rsp_data_next.status = STATUS_FREED;
                    rsp_data_next.frame  = rd_entry.frame;
                end
                else
                begin
                    rsp_data_next.status = STATUS_NOT_MAPPED;
                end
            end
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the request and the response payload
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            mode_reg <= req.data.mode;
            wr_reg   <= req.data.write_access;
            idx_reg  <= idx_lut[req.data.virtual_page];
        end
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule

>>> tb/sv/pfa_mapping_checker.sv
`timescale 1ns / 1ps

module pfa_mapping_checker
    import pfa_pkg::*;
#(
    parameter int ENTRIES_PER_DIRECTORY = 16,
    parameter int DIRECTORIES           = 16,
    parameter int FRAMES                = 128
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req_data,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp_data,
    output int   mismatches,
    output int   outstanding
);

    localparam int   TABLE_SIZE     = ENTRIES_PER_DIRECTORY * DIRECTORIES;

    // Shadow page table and frame bitmap
    logic               page_mapped   [TABLE_SIZE];
    logic               page_writable [TABLE_SIZE];
    logic [FRAME_W-1:0] page_frame    [TABLE_SIZE];
    logic               frame_taken   [FRAMES];

    rsp_t awaited_rsp [$];
    int   error_count;

    task automatic flag_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        error_count++;
    endtask

    // Fold the directory index back into range, as the table does
    function automatic int table_slot(input logic [PAGE_W-1:0] page);
        int dir;
        int ent;
        dir = (int'(page) / ENTRIES_PER_DIRECTORY) % DIRECTORIES;
        ent = int'(page) % ENTRIES_PER_DIRECTORY;
        return dir * ENTRIES_PER_DIRECTORY + ent;
    endfunction

    // Apply one request to the shadow state and return the response it yields
    function automatic rsp_t map_or_unmap(input req_t r);
        rsp_t res;
        int   slot;
        int   f;
        int   i;
        res  = '0;
        slot = table_slot(r.virtual_page);
        if (r.mode == MODE_ALLOCATE)
        begin
            if (page_mapped[slot])
            begin
                res.status = STATUS_ALREADY_MAPPED;
            end
            else
            begin
                // Lowest free frame wins
                f = FRAMES;
                for (i = FRAMES - 1; i >= 0; i--)
                begin
                    if (!frame_taken[i])
                    begin
                        f = i;
                    end
                end
                if (f == FRAMES)
                begin
                    res.status = STATUS_NO_FREE_FRAME;
                end
                else
                begin
                    frame_taken[f]      = 1'b1;
                    page_mapped[slot]   = 1'b1;
                    page_writable[slot] = r.write_access;
                    page_frame[slot]    = FRAME_W'(f);
                    res.status          = STATUS_ALLOCATED;
                    res.frame           = FRAME_W'(f);
                    res.writable        = r.write_access;
                end
            end
        end
        else
        begin
            if (!page_mapped[slot])
            begin
                res.status = STATUS_NOT_MAPPED;
            end
            else
            begin
                f = int'(page_frame[slot]);
                if (f < FRAMES)
                begin
                    frame_taken[f] = 1'b0;
                end
                page_mapped[slot]   = 1'b0;
                page_writable[slot] = 1'b0;
                page_frame[slot]    = '0;
                res.status          = STATUS_FREED;
                res.frame           = FRAME_W'(f);
            end
        end
        return res;
    endfunction

    // Retire responses against the oldest expectation, then log new requests
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < TABLE_SIZE; k++)
            begin
                page_mapped[k]   = 1'b0;
                page_writable[k] = 1'b0;
                page_frame[k]    = '0;
            end
            for (int k = 0; k < FRAMES; k++)
            begin
                frame_taken[k] = 1'b0;
            end
            awaited_rsp.delete();
            error_count = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    flag_mismatch($sformatf("response %0h with no request pending", rsp_data));
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp_data.status !== want.status)
                    begin
                        flag_mismatch($sformatf("status got %0d, expected %0d",
                                                rsp_data.status, want.status));
                    end
                    if (rsp_data.frame !== want.frame)
                    begin
                        flag_mismatch($sformatf("frame got %0d, expected %0d",
                                                rsp_data.frame, want.frame));
                    end
                    if (rsp_data.writable !== want.writable)
                    begin
                        flag_mismatch($sformatf("writable got %0d, expected %0d",
                                                rsp_data.writable, want.writable));
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                awaited_rsp.push_back(map_or_unmap(req_data));
            end
            mismatches  <= error_count;
            outstanding <= awaited_rsp.size();
        end
    end

endmodule

>>> tb/sv/tb_page_frame_allocator.sv
`timescale 1ns / 1ps

module tb_page_frame_allocator;
    import pfa_pkg::*;

    localparam int   ENTRIES_PER_DIRECTORY = 16;
    localparam int   DIRECTORIES           = 16;
    localparam int   FRAMES                = 128;
    localparam int   STALL_LIMIT           = 5000;
    localparam int   DRAIN_CYCLES          = 20;
    localparam int   PHASE_REQUESTS        = 220;
    localparam int   FULL_HITS_TO_DRAIN    = 6;
    localparam int   REFILL_BELOW          = 8;

    logic clk = 1'b0;
    logic rst_n;

    pfa_stream_if #(.payload_t(req_t)) req_chan ();
    pfa_stream_if #(.payload_t(rsp_t)) rsp_chan ();

    int mismatches;
    int outstanding;
    int send_idle_pct;
    int recv_stall_pct;

    // Rough view of which pages hold a frame, used only to steer stimulus
    logic mapped_hint [PAGES];
    int   mapped_count;
    int   full_hits;
    logic filling;

    always #4 clk = ~clk;

    page_frame_allocator #(
        .ENTRIES_PER_DIRECTORY (ENTRIES_PER_DIRECTORY),
        .DIRECTORIES           (DIRECTORIES),
        .FRAMES                (FRAMES)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_chan),
        .rsp   (rsp_chan)
    );

    pfa_mapping_checker #(
        .ENTRIES_PER_DIRECTORY (ENTRIES_PER_DIRECTORY),
        .DIRECTORIES           (DIRECTORIES),
        .FRAMES                (FRAMES)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_chan.valid),
        .req_ready   (req_chan.ready),
        .req_data    (req_chan.data),
        .rsp_valid   (rsp_chan.valid),
        .rsp_ready   (rsp_chan.ready),
        .rsp_data    (rsp_chan.data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Stall the response side at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_chan.ready <= 1'b0;
        end
        else
        begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Present one request after a random gap and hold it until taken
    task automatic send_request(input logic mode, input logic [PAGE_W-1:0] page,
                                input logic wr);
        req_t r;
        r.mode         = mode;
        r.virtual_page = page;
        r.write_access = wr;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_chan.valid <= 1'b0;
            @(posedge clk);
        end
        req_chan.valid <= 1'b1;
        req_chan.data  <= r;
        @(posedge clk);
        while (!req_chan.ready)
        begin
            @(posedge clk);
        end
        // Track the table roughly so that fills and drains can be steered
        if (mode == MODE_ALLOCATE && !mapped_hint[page])
        begin
            if (mapped_count < FRAMES)
            begin
                mapped_hint[page] = 1'b1;
                mapped_count++;
            end
            else
            begin
                full_hits++;
            end
        end
        else if (mode == MODE_FREE && mapped_hint[page])
        begin
            mapped_hint[page] = 1'b0;
            mapped_count--;
        end
    endtask

    // Alternate fill and drain runs so that frame exhaustion is hit repeatedly
    task automatic random_requests(input int count);
        int          n;
        int          tries;
        logic        mode;
        logic [7:0]  page;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_request(1'($urandom_range(1)), 8'($urandom_range(255)),
                             1'($urandom_range(1)));
            end
            else
            begin
                mode = filling ? ($urandom_range(99) < 15) : ($urandom_range(99) < 85);
                page = 8'($urandom_range(255));
                tries = 0;
                while (mapped_hint[page] != mode && tries < 64)
                begin
                    page = 8'($urandom_range(255));
                    tries++;
                end
                send_request(mode, page, 1'($urandom_range(1)));
            end
            if (filling && full_hits >= FULL_HITS_TO_DRAIN)
            begin
                filling = 1'b0;
            end
            else if (!filling && mapped_count < REFILL_BELOW)
            begin
                filling   = 1'b1;
                full_hits = 0;
            end
        end
    endtask

    // Stimulus
    initial
    begin
        rst_n          <= 1'b0;
        req_chan.valid <= 1'b0;
        req_chan.data  <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mapped_count   = 0;
        full_hits      = 0;
        filling        = 1'b1;
        for (int k = 0; k < PAGES; k++)
        begin
            mapped_hint[k] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: first map, duplicate map, double free, frame reuse
        send_request(MODE_ALLOCATE, 8'd0,   1'b0);
        send_request(MODE_ALLOCATE, 8'd255, 1'b1);
        send_request(MODE_ALLOCATE, 8'd0,   1'b1);
        send_request(MODE_FREE,     8'd0,   1'b0);
        send_request(MODE_FREE,     8'd0,   1'b1);
        send_request(MODE_FREE,     8'd170, 1'b0);
        send_request(MODE_ALLOCATE, 8'd85,  1'b1);
        send_request(MODE_ALLOCATE, 8'd0,   1'b1);
        send_request(MODE_FREE,     8'd255, 1'b1);
        send_request(MODE_ALLOCATE, 8'd128, 1'b0);
        send_request(MODE_ALLOCATE, 8'd127, 1'b1);
        send_request(MODE_ALLOCATE, 8'd128, 1'b0);
        send_request(MODE_FREE,     8'd85,  1'b0);
        send_request(MODE_FREE,     8'd0,   1'b0);
        send_request(MODE_FREE,     8'd128, 1'b1);
        send_request(MODE_FREE,     8'd127, 1'b0);

        // Random: no idling, sender idle, receiver stalling, both
        random_requests(PHASE_REQUESTS);
        send_idle_pct = 87;
        random_requests(PHASE_REQUESTS);
        send_idle_pct  = 0;
        recv_stall_pct = 87;
        random_requests(PHASE_REQUESTS);
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        random_requests(PHASE_REQUESTS);
        req_chan.valid <= 1'b0;

        // Drain every pending response, then let the pipeline settle
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Abort when no transaction moves for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("timeout after %0d idle cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
